FILE: hw/rtl/cmsd_pkg.sv
// ----------------------------------------------------------------------------
// cmsd_pkg: shared types and constants for the motor state detector
// Payload structs, register indexes, mode codes and controller interface.
// ----------------------------------------------------------------------------
package cmsd_pkg;

  localparam int SAMPLE_W = 12;
  localparam int TIME_W   = 32;
  localparam int CUR_W    = 20;
  localparam int MODE_W   = 2;
  localparam int LEN_W    = 10;
  localparam int GAIN_W   = 16;
  localparam int STIME_W  = 16;
  localparam int SUM_W    = 22;
  localparam int ZREF_W   = 16;
  localparam int FRAC_W   = 4;
  // sum * 16 + len / 2 fits in this many bits
  localparam int NUM_W    = SUM_W + FRAC_W + 1;
  localparam int PROD_W   = NUM_W + GAIN_W;
  localparam int RND_W    = PROD_W + 1;
  localparam int SHIFT_W  = 12;
  localparam int DIV_CNT_W = $clog2(NUM_W);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_LEN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MEAS_LEN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ON_TH      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_OFF_TH     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_START_TIME = 3'd6;

  // reset values of the configuration registers
  localparam logic [LEN_W-1:0]   RST_ZERO_LEN   = 10'd500;
  localparam logic [LEN_W-1:0]   RST_MEAS_LEN   = 10'd100;
  localparam logic [GAIN_W-1:0]  RST_GAIN       = 16'd8192;
  localparam logic [CUR_W-1:0]   RST_DEADBAND   = 20'd80;
  localparam logic [CUR_W-1:0]   RST_ON_TH      = 20'd250;
  localparam logic [CUR_W-1:0]   RST_OFF_TH     = 20'd150;
  localparam logic [STIME_W-1:0] RST_START_TIME = 16'd3000;

  // motor modes
  localparam logic [MODE_W-1:0] MODE_OFF     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_STARTUP = 2'd1;
  localparam logic [MODE_W-1:0] MODE_STEADY  = 2'd2;

  localparam logic [CUR_W-1:0] CUR_MAX = {CUR_W{1'b1}};

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample_mv;
    logic [TIME_W-1:0]   now_ms;
  } sample_t;

  typedef struct packed {
    logic [CUR_W-1:0]  current_ma;
    logic [MODE_W-1:0] motor_mode;
    logic [CUR_W-1:0]  peak_ma;
  } result_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] value;
  } cfg_t;

  // controller to datapath
  typedef struct packed {
    logic div_step;
    logic cal_commit;
    logic dev_load;
    logic mul_load;
    logic cur_load;
    logic commit;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic block_end;
    logic calibrating;
    logic out_free;
  } dp_status_t;

endpackage

FILE: hw/rtl/cmsd_ifs.sv
// ----------------------------------------------------------------------------
// cmsd_ifs: valid/ready channels of the motor state detector
// Sample input, result output and configuration write channels.
// ----------------------------------------------------------------------------
interface cmsd_sample_if;
  logic               valid;
  logic               ready;
  cmsd_pkg::sample_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface cmsd_result_if;
  logic               valid;
  logic               ready;
  cmsd_pkg::result_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface cmsd_cfg_if;
  logic            valid;
  logic            ready;
  cmsd_pkg::cfg_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: hw/rtl/cmsd_ctrl.sv
// ----------------------------------------------------------------------------
// cmsd_ctrl: sequencer of the motor state detector
// Divide, then deviation, multiply, scale and commit, or a zero-ref commit.
// ----------------------------------------------------------------------------
module cmsd_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  cmsd_pkg::dp_status_t status,
  output cmsd_pkg::dp_cmd_t    cmd
);
  import cmsd_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_DEV,
    S_MUL,
    S_CUR,
    S_HOLD
  } state_t;

  state_t               state;
  logic [DIV_CNT_W-1:0] div_cnt;

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      div_cnt <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid && status.block_end) begin
            state   <= S_DIV;
            div_cnt <= '0;
          end
        end
        S_DIV: begin
          div_cnt <= div_cnt + 1'b1;
          if (div_cnt == DIV_CNT_W'(NUM_W - 1)) begin
            state <= S_DEV;
          end
        end
        S_DEV: begin
          state <= status.calibrating ? S_IDLE : S_MUL;
        end
        S_MUL: state <= S_CUR;
        S_CUR: state <= S_HOLD;
        S_HOLD: begin
          if (status.out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd            = '0;
    cmd.div_step   = (state == S_DIV);
    cmd.cal_commit = (state == S_DEV) && status.calibrating;
    cmd.dev_load   = (state == S_DEV) && !status.calibrating;
    cmd.mul_load   = (state == S_MUL);
    cmd.cur_load   = (state == S_CUR);
    cmd.commit     = (state == S_HOLD) && status.out_free;
  end

endmodule

FILE: hw/rtl/cmsd_dp.sv
// ----------------------------------------------------------------------------
// cmsd_dp: datapath of the motor state detector
// Config registers, block accumulator, serial divider, gain multiplier,
// mode detector and result register.
// ----------------------------------------------------------------------------
module cmsd_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_accept,
  input  cmsd_pkg::sample_t    in_data,
  input  logic                 cfg_accept,
  input  cmsd_pkg::cfg_t       cfg_data,
  input  cmsd_pkg::dp_cmd_t    cmd,
  output cmsd_pkg::dp_status_t status,
  output logic                 res_valid,
  input  logic                 res_ready,
  output cmsd_pkg::result_t    res_data
);
  import cmsd_pkg::*;

  // configuration
  logic [LEN_W-1:0]   zero_len;
  logic [LEN_W-1:0]   meas_len;
  logic [GAIN_W-1:0]  gain;
  logic [CUR_W-1:0]   deadband;
  logic [CUR_W-1:0]   on_th;
  logic [CUR_W-1:0]   off_th;
  logic [STIME_W-1:0] start_time;

  // block and detector state
  logic               calibrating;
  logic [LEN_W-1:0]   sample_count;
  logic [SUM_W-1:0]   sample_sum;
  logic [ZREF_W-1:0]  zero_ref;
  logic [MODE_W-1:0]  mode;
  logic [TIME_W-1:0]  run_start;
  logic [CUR_W-1:0]   peak;

  // arithmetic pipeline
  logic [NUM_W-1:0]   quo;
  logic [LEN_W-1:0]   rem;
  logic [LEN_W-1:0]   den;
  logic [TIME_W-1:0]  now_lat;
  logic [NUM_W-1:0]   dev;
  logic [PROD_W-1:0]  prod;
  logic [CUR_W-1:0]   cur;

  logic [LEN_W-1:0]   len_raw;
  logic [LEN_W-1:0]   len;
  logic [SUM_W-1:0]   sum_new;
  logic [NUM_W-1:0]   numer;
  logic [LEN_W:0]     rem_sh;
  logic               rem_ge;
  logic [NUM_W-1:0]   zref_ext;
  logic [RND_W-1:0]   rnd;
  logic [CUR_W-1:0]   cur_sat;
  logic [TIME_W-1:0]  elapsed;
  logic [MODE_W-1:0]  mode_next;
  logic [TIME_W-1:0]  run_start_next;
  logic [CUR_W-1:0]   peak_next;

  // block length in force; zero acts as one
  assign len_raw = calibrating ? zero_len : meas_len;
  assign len     = (len_raw == '0) ? LEN_W'(1) : len_raw;
  assign sum_new = sample_sum + SUM_W'(in_data.sample_mv);
  assign numer   = NUM_W'({sum_new, {FRAC_W{1'b0}}}) + NUM_W'(len[LEN_W-1:1]);

  assign status.block_end   = ({1'b0, sample_count} + (LEN_W+1)'(1)) >= {1'b0, len};
  assign status.calibrating = calibrating;
  assign status.out_free    = !res_valid || res_ready;

  // restoring divider, one quotient bit per step
  assign rem_sh = {rem, quo[NUM_W-1]};
  assign rem_ge = rem_sh >= {1'b0, den};

  assign zref_ext = NUM_W'(zero_ref);

  assign rnd     = RND_W'(prod) + RND_W'(1 << (SHIFT_W - 1));
  assign cur_sat = (rnd[RND_W-1:SHIFT_W+CUR_W] != '0) ? CUR_MAX
                                                       : rnd[SHIFT_W+CUR_W-1:SHIFT_W];

  assign elapsed = now_lat - run_start;

  always_comb begin
    mode_next      = mode;
    run_start_next = run_start;
    peak_next      = peak;
    unique case (mode)
      MODE_OFF: begin
        if (cur >= on_th) begin
          mode_next      = MODE_STARTUP;
          run_start_next = now_lat;
          peak_next      = cur;
        end
      end
      MODE_STARTUP: begin
        if (cur > peak) begin
          peak_next = cur;
        end
        if (cur <= off_th) begin
          mode_next = MODE_OFF;
          peak_next = '0;
        end else if (elapsed >= TIME_W'(start_time)) begin
          mode_next = MODE_STEADY;
        end
      end
      MODE_STEADY: begin
        if (cur <= off_th) begin
          mode_next = MODE_OFF;
          peak_next = '0;
        end
      end
      default: mode_next = MODE_OFF;
    endcase
  end

  // configuration writes; drop unknown indexes
  always_ff @(posedge clk) begin
    if (rst) begin
      zero_len   <= RST_ZERO_LEN;
      meas_len   <= RST_MEAS_LEN;
      gain       <= RST_GAIN;
      deadband   <= RST_DEADBAND;
      on_th      <= RST_ON_TH;
      off_th     <= RST_OFF_TH;
      start_time <= RST_START_TIME;
    end else if (cfg_accept) begin
      unique case (cfg_data.index)
        CFG_ZERO_LEN:   zero_len   <= cfg_data.value[LEN_W-1:0];
        CFG_MEAS_LEN:   meas_len   <= cfg_data.value[LEN_W-1:0];
        CFG_GAIN:       gain       <= cfg_data.value[GAIN_W-1:0];
        CFG_DEADBAND:   deadband   <= cfg_data.value[CUR_W-1:0];
        CFG_ON_TH:      on_th      <= cfg_data.value[CUR_W-1:0];
        CFG_OFF_TH:     off_th     <= cfg_data.value[CUR_W-1:0];
        CFG_START_TIME: start_time <= cfg_data.value[STIME_W-1:0];
        default: ;
      endcase
    end
  end

  // architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      calibrating  <= 1'b1;
      sample_count <= '0;
      sample_sum   <= '0;
      zero_ref     <= '0;
      mode         <= MODE_OFF;
      run_start    <= '0;
      peak         <= '0;
      res_valid    <= 1'b0;
    end else begin
      if (in_accept) begin
        if (status.block_end) begin
          sample_count <= '0;
          sample_sum   <= '0;
        end else begin
          sample_count <= sample_count + 1'b1;
          sample_sum   <= sum_new;
        end
      end
      if (cmd.cal_commit) begin
        zero_ref    <= quo[ZREF_W-1:0];
        calibrating <= 1'b0;
      end
      if (cmd.commit) begin
        mode      <= mode_next;
        run_start <= run_start_next;
        peak      <= peak_next;
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_accept && status.block_end) begin
      quo     <= numer;
      rem     <= '0;
      den     <= len;
      now_lat <= in_data.now_ms;
    end else if (cmd.div_step) begin
      quo <= {quo[NUM_W-2:0], rem_ge};
      rem <= rem_ge ? LEN_W'(rem_sh - {1'b0, den}) : rem_sh[LEN_W-1:0];
    end
    if (cmd.dev_load) begin
      dev <= (zref_ext >= quo) ? (zref_ext - quo) : (quo - zref_ext);
    end
    if (cmd.mul_load) begin
      prod <= PROD_W'(dev) * PROD_W'(gain);
    end
    if (cmd.cur_load) begin
      cur <= (cur_sat < deadband) ? '0 : cur_sat;
    end
    if (cmd.commit) begin
      res_data.current_ma <= cur;
      res_data.motor_mode <= mode_next;
      res_data.peak_ma    <= peak_next;
    end
  end

endmodule

FILE: hw/rtl/current_sense_motor_state_detector.sv
// ----------------------------------------------------------------------------
// current_sense_motor_state_detector: block-average current sensing with
// a hysteresis off/startup/steady motor detector
// ----------------------------------------------------------------------------
// A sample that closes a measured block passes through the 27-step serial
// divider, then deviation, multiply, scale and commit; the commit waits
// until the output register is free. Inside a block one sample is taken
// per cycle; at a block end the input is held until the sequencer is idle,
// for the zero block after the divider and the zero-reference commit.
// Reset (synchronous, rst high): config to defaults, zero calibration pending.
// ----------------------------------------------------------------------------
module current_sense_motor_state_detector (
  input  logic            clk,
  input  logic            rst,
  cmsd_sample_if.sink     sample_ch,
  cmsd_result_if.source   result_ch,
  cmsd_cfg_if.sink        cfg_ch
);
  import cmsd_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;
  logic       in_ready;
  logic       in_accept;
  logic       cfg_accept;

  // Samples enter only while the sequencer is idle; a finished result waits
  // in the output register, so new samples keep accumulating behind it.
  assign sample_ch.ready = in_ready;
  assign in_accept       = sample_ch.valid && in_ready;

  // Config writes are taken at any time; they are expected only when idle.
  assign cfg_ch.ready = 1'b1;
  assign cfg_accept   = cfg_ch.valid;

  // Sequencer: walk each closed block through the datapath stages and
  // hold the commit until the output register is free.
  cmsd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (sample_ch.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Datapath: accumulate, divide by the block length, scale by the gain,
  // apply deadband and saturation, update the mode detector.
  cmsd_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .in_accept  (in_accept),
    .in_data    (sample_ch.data),
    .cfg_accept (cfg_accept),
    .cfg_data   (cfg_ch.data),
    .cmd        (cmd),
    .status     (status),
    .res_valid  (result_ch.valid),
    .res_ready  (result_ch.ready),
    .res_data   (result_ch.data)
  );

endmodule

FILE: verif/current_sense_motor_state_detector_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// current_sense_motor_state_detector_tb: self-checking bench for the detector
// Feeds millivolt samples with time stamps over the sample channel, keeps its
// own copy of the block averager and off/startup/steady detector, and checks
// every reading that leaves the block field by field against that copy.
// ----------------------------------------------------------------------------
module current_sense_motor_state_detector_tb;
  import cmsd_pkg::*;

  // cycles to let a closing block finish its divider before touching config
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned MAX_IDLE      = 11;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
  localparam logic [SAMPLE_W-1:0]  MID_MV     = 12'd2048;
  localparam logic [SAMPLE_W-1:0]  FULL_MV    = 12'hFFF;

  logic clk;
  logic rst;

  cmsd_sample_if sample_ch();
  cmsd_result_if result_ch();
  cmsd_cfg_if    cfg_ch();

  current_sense_motor_state_detector DUT (
    .clk       (clk),
    .rst       (rst),
    .sample_ch (sample_ch),
    .result_ch (result_ch),
    .cfg_ch    (cfg_ch)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // --------------------------------------------------------------------------
  // Detector copy: configuration, block accumulator and mode state
  // --------------------------------------------------------------------------
  logic [LEN_W-1:0]   zero_len_q  = RST_ZERO_LEN;
  logic [LEN_W-1:0]   meas_len_q  = RST_MEAS_LEN;
  logic [GAIN_W-1:0]  gain_q      = RST_GAIN;
  logic [CUR_W-1:0]   deadband_q  = RST_DEADBAND;
  logic [CUR_W-1:0]   on_th_q     = RST_ON_TH;
  logic [CUR_W-1:0]   off_th_q    = RST_OFF_TH;
  logic [STIME_W-1:0] startup_q   = RST_START_TIME;

  bit                 cal_pending = 1'b1;
  logic [LEN_W-1:0]   blk_count   = '0;
  logic [SUM_W-1:0]   blk_sum     = '0;
  logic [ZREF_W-1:0]  zero_ref_q4 = '0;
  logic [MODE_W-1:0]  mode_q      = MODE_OFF;
  logic [TIME_W-1:0]  run_start   = '0;
  logic [CUR_W-1:0]   peak_q      = '0;

  result_t     predicted_readings[$];
  int unsigned mismatch_count = 0;

  // traffic shaping shared by the tests and the two channel processes
  bit          src_gaps     = 1'b1;
  bit          sink_stalls  = 1'b1;
  int unsigned hold_request = 0;
  bit          sink_held    = 1'b0;

  // Mirror one register write; bits above the register width drop out.
  function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] val);
    case (idx)
      CFG_ZERO_LEN:   zero_len_q = val[LEN_W-1:0];
      CFG_MEAS_LEN:   meas_len_q = val[LEN_W-1:0];
      CFG_GAIN:       gain_q     = val[GAIN_W-1:0];
      CFG_DEADBAND:   deadband_q = val[CUR_W-1:0];
      CFG_ON_TH:      on_th_q    = val[CUR_W-1:0];
      CFG_OFF_TH:     off_th_q   = val[CUR_W-1:0];
      CFG_START_TIME: startup_q  = val[STIME_W-1:0];
      default: ;
    endcase
  endfunction

  // Accumulate one accepted sample; at a measured block end queue its reading.
  task automatic advance_detector(input logic [SAMPLE_W-1:0] mv,
                                  input logic [TIME_W-1:0] now);
    int unsigned       len;
    longint unsigned   avg;
    longint unsigned   dev;
    longint unsigned   cur;
    logic [CUR_W-1:0]  c;
    logic [TIME_W-1:0] elapsed;
    result_t           r;

    len = cal_pending ? zero_len_q : meas_len_q;
    if (len == 0) len = 1;
    blk_sum = blk_sum + mv;
    if (blk_count + 1 < len) begin
      blk_count = blk_count + 1'b1;
      return;
    end

    // q4 average, rounded to nearest with halves up
    avg = (64'(blk_sum) * 16 + len / 2) / len;
    blk_sum   = '0;
    blk_count = '0;

    if (cal_pending) begin
      zero_ref_q4 = avg[ZREF_W-1:0];
      cal_pending = 1'b0;
      return;
    end

    dev = (zero_ref_q4 >= avg) ? zero_ref_q4 - avg : avg - zero_ref_q4;
    cur = (dev * gain_q + 2048) >> SHIFT_W;
    if (cur > CUR_MAX) cur = CUR_MAX;
    if (cur < deadband_q) cur = 0;
    c = cur[CUR_W-1:0];

    case (mode_q)
      MODE_OFF: begin
        if (c >= on_th_q) begin
          mode_q    = MODE_STARTUP;
          run_start = now;
          peak_q    = c;
        end
      end
      MODE_STARTUP: begin
        if (c > peak_q) peak_q = c;
        elapsed = now - run_start;
        if (c <= off_th_q) begin
          mode_q = MODE_OFF;
          peak_q = '0;
        end else if (elapsed >= startup_q) begin
          mode_q = MODE_STEADY;
        end
      end
      MODE_STEADY: begin
        if (c <= off_th_q) begin
          mode_q = MODE_OFF;
          peak_q = '0;
        end
      end
      default: mode_q = MODE_OFF;
    endcase

    r.current_ma = c;
    r.motor_mode = mode_q;
    r.peak_ma    = peak_q;
    predicted_readings.push_back(r);
  endtask

  task automatic check_reading(input result_t got);
    result_t want;
    if (predicted_readings.size() == 0) begin
      $display("%0t: reading with none expected, actual current=%0d mode=%0d peak=%0d",
               $time, got.current_ma, got.motor_mode, got.peak_ma);
      mismatch_count++;
      return;
    end
    want = predicted_readings.pop_front();
    if (got.current_ma !== want.current_ma) begin
      $display("%0t: current_ma expected %0d actual %0d",
               $time, want.current_ma, got.current_ma);
      mismatch_count++;
    end
    if (got.motor_mode !== want.motor_mode) begin
      $display("%0t: motor_mode expected %0d actual %0d",
               $time, want.motor_mode, got.motor_mode);
      mismatch_count++;
    end
    if (got.peak_ma !== want.peak_ma) begin
      $display("%0t: peak_ma expected %0d actual %0d",
               $time, want.peak_ma, got.peak_ma);
      mismatch_count++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Channel helpers
  // --------------------------------------------------------------------------

  // Offer one item; valid stays high after acceptance so back-to-back items
  // never drop it. Any caller that lets time pass next lowers it first.
  task automatic send_sample(input logic [SAMPLE_W-1:0] mv,
                             input logic [TIME_W-1:0] now);
    int unsigned gap;
    gap = src_gaps ? $urandom_range(0, MAX_IDLE) : 0;
    if (gap > 0) begin
      sample_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_ch.valid <= 1'b1;
    sample_ch.data  <= '{sample_mv: mv, now_ms: now};
    do @(posedge clk); while (!sample_ch.ready);
    advance_detector(mv, now);
  endtask

  // Stop offering, wait out every queued reading, then let a closing block
  // that gives no reading run through its divider.
  task automatic wait_for_readings();
    sample_ch.valid <= 1'b0;
    while (predicted_readings.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= '{index: idx, value: val};
    do @(posedge clk); while (!cfg_ch.ready);
    apply_register(idx, val);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Reading sink: check each accepted reading, then stall a random number of
  // cycles before the next one; a long hold from the counter below overrides.
  initial begin : reading_sink
    int unsigned stall_left;
    stall_left      = 0;
    result_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result_ch.valid && result_ch.ready) begin
        check_reading(result_ch.data);
        stall_left = sink_stalls ? $urandom_range(0, MAX_IDLE) : 0;
      end else if (stall_left > 0) begin
        stall_left--;
      end
      result_ch.ready <= !rst && stall_left == 0 && !sink_held;
    end
  end

  // Long receiver hold-off, counted here so the sender can keep pushing.
  initial begin : sink_hold_counter
    wait (hold_request > 0);
    @(posedge clk);
    sink_held = 1'b1;
    repeat (hold_request) @(posedge clk);
    sink_held = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // A zero block length acts as one: a single mid-scale sample sets the zero
  // reference and gives no reading. The measured length of zero also acts as
  // one for the tests that follow.
  task automatic test_zero_calibration();
    write_reg(CFG_ZERO_LEN, '0);
    write_reg(CFG_MEAS_LEN, '0);
    send_sample(MID_MV, 32'd0);
    wait_for_readings();
  endtask

  // Reset gain, deadband, thresholds and startup time: 32 mA per mV, so a few
  // mV of deviation walk through deadband, on, off and the startup timer,
  // with deviations on both sides of zero and both sample extremes.
  task automatic test_reset_detector();
    send_sample(MID_MV,         32'd100);   // zero current
    send_sample(MID_MV + 12'd2, 32'd200);   // under the deadband
    send_sample(MID_MV + 12'd3, 32'd300);   // above deadband, below on
    send_sample(MID_MV - 12'd8, 32'd1000);  // at on from below zero: startup
    send_sample(MID_MV + 12'd12, 32'd1100); // raise the peak
    send_sample(MID_MV + 12'd5, 32'd1200);  // just over off: hold startup
    send_sample(MID_MV + 12'd10, 32'd4000); // startup time reached: steady
    send_sample(FULL_MV,        32'd4100);  // steady keeps the startup peak
    send_sample(12'd0,          32'd4200);
    send_sample(MID_MV + 12'd4, 32'd4300);  // at or below off: off, peak clear
    wait_for_readings();
  endtask

  // Startup time measured across the 32-bit time stamp wrap.
  task automatic test_time_wrap();
    send_sample(MID_MV + 12'd12, 32'hFFFF_FF00);
    send_sample(MID_MV + 12'd12, 32'h0000_0AB7); // 2999 ms: still startup
    send_sample(MID_MV + 12'd12, 32'h0000_0AB8); // 3000 ms: steady
    send_sample(MID_MV,          32'hFFFF_FFFF);
    wait_for_readings();
  endtask

  // Shrink the measured length while a block is half full: the next sample
  // closes it, then a clean block of the new length follows.
  task automatic test_midblock_length();
    int unsigned i;
    write_reg(CFG_MEAS_LEN, 20'd8);
    for (i = 0; i < 5; i++) send_sample(MID_MV + 12'(i * 7), 32'(5000 + i));
    wait_for_readings();
    write_reg(CFG_MEAS_LEN, 20'd3);
    send_sample(MID_MV + 12'd40, 32'd5100);
    send_sample(MID_MV + 12'd1, 32'd5200);
    send_sample(MID_MV + 12'd2, 32'd5300);
    send_sample(MID_MV + 12'd2, 32'd5400);
    wait_for_readings();
  endtask

  // Register extremes: oversized values lose their top bits, the unused index
  // changes nothing, zero and full-scale thresholds and startup times.
  task automatic test_register_limits();
    write_reg(CFG_GAIN, 20'hFFFFF);
    write_reg(CFG_UNUSED, 20'h12345);
    write_reg(CFG_ZERO_LEN, 20'hFFFFF);
    write_reg(CFG_MEAS_LEN, 20'd1);
    write_reg(CFG_DEADBAND, '0);
    write_reg(CFG_ON_TH, '0);
    write_reg(CFG_OFF_TH, '0);
    write_reg(CFG_START_TIME, '0);
    send_sample(MID_MV, 32'd0);      // zero meets an on threshold of zero
    send_sample(FULL_MV, 32'd0);     // no startup time: steady at once
    send_sample(12'd0, 32'd1);
    send_sample(MID_MV, 32'd2);      // back to zero: off
    wait_for_readings();
    write_reg(CFG_DEADBAND, CUR_MAX);
    write_reg(CFG_ON_TH, CUR_MAX);
    write_reg(CFG_OFF_TH, CUR_MAX);
    write_reg(CFG_START_TIME, 20'h0FFFF);
    send_sample(FULL_MV, 32'd10);    // whole range sits under the deadband
    send_sample(12'd0, 32'd20);
    wait_for_readings();
  endtask

  // One long block of 600 full-scale samples: the accumulator reaches its top
  // bit and the divisor uses every length bit; no idling so the run stays short.
  task automatic test_longest_block();
    int unsigned i;
    src_gaps    = 1'b0;
    sink_stalls = 1'b0;
    write_reg(CFG_DEADBAND, RST_DEADBAND);
    write_reg(CFG_ON_TH, RST_ON_TH);
    write_reg(CFG_OFF_TH, RST_OFF_TH);
    write_reg(CFG_MEAS_LEN, 20'd600);
    for (i = 0; i < 600; i++) send_sample(FULL_MV, 32'(i));
    wait_for_readings();
  endtask

  // Hold the receiver off for a long stretch while the sender keeps offering
  // one-sample blocks, so the block fills and stalls its input.
  task automatic test_output_backpressure();
    int unsigned       i;
    logic [TIME_W-1:0] t;
    src_gaps    = 1'b0;
    sink_stalls = 1'b0;
    write_reg(CFG_MEAS_LEN, 20'd1);
    t = $urandom;
    hold_request = HOLD_CYCLES;
    for (i = 0; i < 24; i++) begin
      send_sample(12'($urandom_range(0, 4095)), t);
      t = t + $urandom_range(0, 500);
    end
    wait_for_readings();
  endtask

  // One random phase: draw a configuration, then drive runs of blocks whose
  // level sits at zero, on the deadband, the thresholds, in between or at the top, with a tenth
  // of the samples as noise and occasional time stamp jumps.
  task automatic run_random_phase(input int unsigned n_items);
    int unsigned       sent;
    int unsigned       blk_len;
    int unsigned       blocks_left;
    int unsigned       left_in_blk;
    int unsigned       top;
    longint unsigned   target;
    longint unsigned   delta;
    bit                below;
    int                level;
    logic [TIME_W-1:0] t;
    logic [SAMPLE_W-1:0] mv;

    src_gaps    = ($urandom_range(0, 3) != 0);
    sink_stalls = ($urandom_range(0, 3) != 0);

    blk_len = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
    write_reg(CFG_MEAS_LEN, 20'(blk_len));
    case ($urandom_range(0, 4))
      0:       write_reg(CFG_GAIN, 20'd1);
      1:       write_reg(CFG_GAIN, 20'h0FFFF);
      2:       write_reg(CFG_GAIN, 20'(RST_GAIN));
      default: write_reg(CFG_GAIN, 20'($urandom_range(1, 16'hFFFF)));
    endcase
    // largest current the mid-scale zero reference allows at this gain
    top = 8 * int'(gain_q);
    case ($urandom_range(0, 4))
      0:       write_reg(CFG_DEADBAND, '0);
      1:       write_reg(CFG_DEADBAND, 20'($urandom_range(0, CUR_MAX)));
      default: write_reg(CFG_DEADBAND, 20'($urandom_range(0, top / 8)));
    endcase
    case ($urandom_range(0, 5))
      0:       write_reg(CFG_ON_TH, '0);
      1:       write_reg(CFG_ON_TH, CUR_MAX);
      default: write_reg(CFG_ON_TH, 20'($urandom_range(0, top)));
    endcase
    case ($urandom_range(0, 4))
      0:       write_reg(CFG_OFF_TH, '0);
      1:       write_reg(CFG_OFF_TH, 20'($urandom_range(0, CUR_MAX)));
      default: write_reg(CFG_OFF_TH, 20'($urandom_range(0, on_th_q)));
    endcase
    case ($urandom_range(0, 4))
      0:       write_reg(CFG_START_TIME, '0);
      1:       write_reg(CFG_START_TIME, 20'h0FFFF);
      default: write_reg(CFG_START_TIME, 20'($urandom_range(0, 400)));
    endcase

    t           = $urandom;
    sent        = 0;
    blocks_left = 0;
    left_in_blk = 0;
    target      = 0;
    below       = 1'b0;
    while (sent < n_items) begin
      if (left_in_blk == 0) begin
        // hold a level for a short run of blocks so the detector can settle
        if (blocks_left == 0) begin
          case ($urandom_range(0, 7))
            0:       target = 0;
            1:       target = deadband_q;
            2:       target = off_th_q;
            3:       target = off_th_q + 1;
            4:       target = (longint'(off_th_q) + on_th_q) / 2;
            5:       target = on_th_q;
            6:       target = (on_th_q > 0) ? on_th_q - 1 : 0;
            default: target = top;
          endcase
          blocks_left = $urandom_range(1, 4);
          below       = $urandom_range(0, 1);
        end
        blocks_left--;
        left_in_blk = blk_len;
      end
      if ($urandom_range(0, 9) == 0) begin
        mv = 12'($urandom_range(0, 4095));
        if ($urandom_range(0, 3) == 0) t = $urandom;
      end else begin
        delta = (target * 256 + gain_q / 2) / gain_q;
        if (delta > 2048) delta = 2048;
        level = below ? int'(MID_MV) - int'(delta) : int'(MID_MV) + int'(delta);
        level = level + int'($urandom_range(0, 2)) - 1;
        if (level < 0) level = 0;
        if (level > 4095) level = 4095;
        mv = level[SAMPLE_W-1:0];
      end
      send_sample(mv, t);
      t = t + $urandom_range(0, 60);
      sent++;
      left_in_blk--;
    end
    wait_for_readings();
  endtask

  task automatic test_random_traffic();
    int unsigned phase;
    for (phase = 0; phase < 6; phase++) run_random_phase(50);
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin : test_sequence
    // drive every input to a known value from time zero
    rst              = 1'b1;
    sample_ch.valid  = 1'b0;
    sample_ch.data   = '0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.data      = '0;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_zero_calibration();
    test_reset_detector();
    test_time_wrap();
    test_midblock_length();
    test_register_limits();
    test_longest_block();
    test_output_backpressure();
    test_random_traffic();

    if (mismatch_count == 0 && predicted_readings.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Guard against a hung handshake: the slowest correct run is far shorter.
  initial begin : run_limit
    #10_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
